@@ hw/rtl/mru_key_list_unit_assert.svh @@
// Assertion macros used by the checker file.
`ifndef MRU_KEY_LIST_UNIT_ASSERT_SVH
`define MRU_KEY_LIST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRUKL_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mru key list check failed");

// The consequent must hold in the cycle after the antecedent.
`define MRUKL_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mru key list check failed");

`endif

@@ hw/rtl/mrukl_pkg.sv @@
package mrukl_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 64;
  localparam int CAP_W    = 5;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W    = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
  } cmd_t;

endpackage

@@ hw/rtl/mrukl_cell.sv @@
module mrukl_cell (
  input  logic          clk,
  input  mrukl_pkg::cmd_t cmd,
  input  mrukl_pkg::key_t prev_key,
  input  mrukl_pkg::key_t next_key,
  input  logic          prev_live,
  input  logic          live,
  input  logic          hit_in,
  output mrukl_pkg::key_t key_q,
  output logic          hit_out
);
  import mrukl_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic match;

  assign match   = live && (key_r == cmd.key);
  assign hit_out = hit_in || match;
  assign key_q   = key_r;

  always_comb begin
    key_nxt = key_r;
    if (cmd.ins && !hit_in && prev_live) begin
      key_nxt = prev_key;
    end else if (cmd.rem && (hit_in || match)) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

@@ hw/rtl/mru_key_list_unit.sv @@
// Insert, remove and clear leave busy low, and the next beat may follow at once.
// A read gives its first result in the cycle after acceptance and one result per cycle after it;
// busy is high while the rest of a run longer than one entry is being read out.
// The receiver cannot stall; each result is shown for exactly one cycle with out_valid.
// Synchronous active-low reset empties the list and sets capacity to 16; keys are not cleared.
module mru_key_list_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [63:0] in_key,
  output logic        out_valid,
  output logic [63:0] out_entry_key,
  output logic [3:0]  out_entry_position,
  output logic        out_last_of_run,
  output logic        out_list_empty,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import mrukl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CAP_W-1:0] cap_r;
  logic             out_valid_r, out_valid_nxt;
  key_t             out_key_r, out_key_nxt;
  logic [3:0]       out_pos_r, out_pos_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_empty_r, out_empty_nxt;

  logic             accept;
  mode_t            mode;
  cmd_t             cmd;
  key_t             cell_key [DEPTH];
  logic [DEPTH-1:0] live;
  logic [DEPTH:0]   hit;
  logic             found;
  logic [IDX_W-1:0] rd_sel;
  key_t             rd_key;
  logic             rd_last;
  logic [SUM_W-1:0] cap_ext, depth_c, eff, cnt_ext, grown, trimmed;

  assign accept   = start && !busy;
  assign mode     = mode_t'(in_mode);
  assign cmd.ins  = accept && (mode == MODE_INSERT);
  assign cmd.rem  = accept && (mode == MODE_REMOVE);
  assign cmd.key  = in_key[KEY_BITS-1:0];
  assign hit[0]   = 1'b0;
  assign found    = hit[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign live[g] = (CNT_W'(g) < count_r);
    mrukl_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .prev_key  ((g == 0) ? cmd.key : cell_key[(g == 0) ? 0 : g - 1]),
      .next_key  ((g == DEPTH - 1) ? cell_key[g] : cell_key[(g == DEPTH - 1) ? g : g + 1]),
      .prev_live ((g == 0) ? 1'b1 : live[(g == 0) ? 0 : g - 1]),
      .live      (live[g]),
      .hit_in    (hit[g]),
      .key_q     (cell_key[g]),
      .hit_out   (hit[g+1])
    );
  end

  always_comb begin
    cap_ext = SUM_W'(cap_r);
    depth_c = SUM_W'(DEPTH);
    cnt_ext = SUM_W'(count_r);
    eff     = (cap_ext < depth_c) ? cap_ext : depth_c;
    if (found) begin
      grown = cnt_ext;
    end else if (cnt_ext < depth_c) begin
      grown = cnt_ext + SUM_W'(1);
    end else begin
      grown = depth_c + SUM_W'(1);
    end
    trimmed = (grown > eff) ? grown - SUM_W'(1) : grown;
    if (trimmed > depth_c) begin
      trimmed = depth_c;
    end
  end

  assign rd_sel  = (state_r == ST_READ) ? idx_r : '0;
  assign rd_key  = cell_key[rd_sel];
  assign rd_last = ((CNT_W'(rd_sel) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_valid_nxt = 1'b0;
    out_key_nxt   = out_key_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_INSERT: count_nxt = CNT_W'(trimmed);
            MODE_REMOVE: begin
              if (found) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            MODE_CLEAR: count_nxt = '0;
            MODE_READ: begin
              out_valid_nxt = 1'b1;
              out_pos_nxt   = '0;
              if (count_r == '0) begin
                out_key_nxt   = '0;
                out_last_nxt  = 1'b1;
                out_empty_nxt = 1'b1;
              end else begin
                out_key_nxt   = rd_key;
                out_last_nxt  = rd_last;
                out_empty_nxt = 1'b0;
                if (!rd_last) begin
                  state_nxt = ST_READ;
                  idx_nxt   = IDX_W'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_key_nxt   = rd_key;
        out_pos_nxt   = 4'(idx_r);
        out_last_nxt  = rd_last;
        out_empty_nxt = 1'b0;
        idx_nxt       = IDX_W'(idx_r + IDX_W'(1));
        if (rd_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      cap_r       <= CAP_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_key_r   <= out_key_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign busy               = (state_r == ST_READ);
  assign out_valid          = out_valid_r;
  assign out_entry_key      = 64'(out_key_r);
  assign out_entry_position = out_pos_r;
  assign out_last_of_run    = out_last_r;
  assign out_list_empty     = out_empty_r;

endmodule

@@ hw/rtl/mrukl_checker.sv @@
`include "mru_key_list_unit_assert.svh"

module mrukl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic [63:0] out_entry_key,
  input logic [3:0]  out_entry_position,
  input logic        out_last_of_run,
  input logic        out_list_empty
);
  import mrukl_pkg::*;

  logic read_beat;

  assign read_beat = start && !busy && (in_mode == MODE_READ);

  `MRUKL_CHK_NOW(a_busy_from_read, $rose(busy), $past(read_beat))
  `MRUKL_CHK_NOW(a_result_source, out_valid, $past(busy) || $past(read_beat))
  `MRUKL_CHK_NOW(a_empty_shape, out_valid && out_list_empty,
                 out_last_of_run && (out_entry_key == 64'd0) && (out_entry_position == 4'd0))
  `MRUKL_CHK_NOW(a_busy_streams, busy, out_valid && !out_last_of_run)
  `MRUKL_CHK_NEXT(a_run_continues, out_valid && !out_last_of_run,
                  out_valid && (out_entry_position == 4'($past(out_entry_position) + 4'd1)))

endmodule

bind mru_key_list_unit mrukl_checker u_mrukl_checker (.*);
